// ===== sv/rsr_pkg.sv =====
package rsr_pkg;

  // field widths fixed by the interface
  localparam int CNT_W     = 17;
  localparam int OUT_POS_W = 32;
  localparam int CAP_W     = 5;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_LOG2_RST = 5'd10;

  // saturation ceiling of an available count
  localparam logic [CNT_W-1:0] AVAIL_MAX = 17'h1FFFF;

  // depth of the command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // request codes
  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ORDERED = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  // input word
  typedef struct packed {
    logic [1:0]           req_type;
    logic                 side;
    logic [CNT_W-1:0]     count;
    logic [OUT_POS_W-1:0] release_position;
  } rsr_in_t;

  // result word
  typedef struct packed {
    logic [CNT_W-1:0]     granted;
    logic [OUT_POS_W-1:0] position;
    logic                 accepted;
  } rsr_out_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e                  op;
    logic                 side;
    logic [CNT_W-1:0]     count;
    logic [OUT_POS_W-1:0] release_position;
    logic [CNT_W-1:0]     init_cap;
  } rsr_cmd_t;

  // slot count loaded by init: 2^min(lg, max_lg), saturated at the count ceiling
  function automatic logic [CNT_W-1:0] load_capacity(input logic [CAP_W-1:0] lg,
                                                     input logic [5:0]       max_lg);
    logic [5:0] lg_eff;
    lg_eff = ({1'b0, lg} > max_lg) ? max_lg : {1'b0, lg};
    if (lg_eff >= 6'(CNT_W)) begin
      return AVAIL_MAX;
    end
    return CNT_W'(1) << lg_eff;
  endfunction

endpackage

// ===== sv/rsr_front.sv =====
module rsr_front import rsr_pkg::*; #(
  parameter int MAX_LOG2 = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rsr_in_t          in_data_i,
  input  logic             q_full_i,
  output logic             push_o,
  output rsr_cmd_t         cmd_o
);

  logic [CAP_W-1:0] cap_log2_q;
  logic [CAP_W-1:0] cap_log2_d;

  // capacity register, always writable
  assign cfg_ready_o = 1'b1;
  assign cap_log2_d  = cfg_valid_i ? cfg_data_i : cap_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q <= CAP_LOG2_RST;
    end else begin
      cap_log2_q <= cap_log2_d;
    end
  end

  // accept while the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the word and attach the init load value
  always_comb begin
    cmd_o.op               = op_e'(in_data_i.req_type);
    cmd_o.side             = in_data_i.side;
    cmd_o.count            = in_data_i.count;
    cmd_o.release_position = in_data_i.release_position;
    cmd_o.init_cap         = load_capacity(cap_log2_q, 6'(MAX_LOG2));
  end

endmodule

// ===== sv/rsr_queue.sv =====
module rsr_queue import rsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rsr_cmd_t data_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output rsr_cmd_t data_o
);

  rsr_cmd_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Q_CNT_W'(Q_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue popped while empty");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !full_o)
    else $error("queue pushed while full");
`endif

endmodule

// ===== sv/rsr_back.sv =====
module rsr_back import rsr_pkg::*; #(
  parameter int MAX_LOG2 = 16,
  parameter int POS_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  rsr_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsr_out_t out_data_o
);

  // bits shared by the 32-bit ports and the position counters
  localparam int RP_W = (POS_BITS < OUT_POS_W) ? POS_BITS : OUT_POS_W;

  logic [CNT_W-1:0]    avail_q   [2];
  logic [CNT_W-1:0]    avail_d   [2];
  logic [POS_BITS-1:0] rsv_pos_q [2];
  logic [POS_BITS-1:0] rsv_pos_d [2];
  logic [POS_BITS-1:0] rel_pos_q [2];
  logic [POS_BITS-1:0] rel_pos_d [2];
  logic                out_valid_q, out_valid_d;
  rsr_out_t            out_data_q, out_data_d;

  logic                sel;
  logic [CNT_W-1:0]    grant;
  logic [CNT_W:0]      sum;
  logic [CNT_W-1:0]    sum_sat;
  logic [POS_BITS-1:0] rpos_ext;

  // take the next command when the output register is free or draining
  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // per-side arithmetic: grant, saturating add, release position match
  assign sel      = cmd_i.side;
  assign grant    = (cmd_i.count < avail_q[sel]) ? cmd_i.count : avail_q[sel];
  assign sum      = {1'b0, avail_q[sel]} + {1'b0, cmd_i.count};
  assign sum_sat  = sum[CNT_W] ? AVAIL_MAX : sum[CNT_W-1:0];
  assign rpos_ext = POS_BITS'(cmd_i.release_position[RP_W-1:0]);

  // execute the command
  always_comb begin
    avail_d     = avail_q;
    rsv_pos_d   = rsv_pos_q;
    rel_pos_d   = rel_pos_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      unique case (cmd_i.op)
        OP_RESERVE: begin
          if (grant != '0) begin
            avail_d[sel]        = avail_q[sel] - grant;
            rsv_pos_d[sel]      = rsv_pos_q[sel] + POS_BITS'(grant);
            out_data_d.granted  = grant;
            out_data_d.position = OUT_POS_W'(rsv_pos_q[sel][RP_W-1:0]);
            out_data_d.accepted = 1'b1;
          end
        end
        OP_RELEASE: begin
          avail_d[sel]        = sum_sat;
          out_data_d.granted  = cmd_i.count;
          out_data_d.accepted = 1'b1;
        end
        OP_ORDERED: begin
          if (rel_pos_q[sel] == rpos_ext) begin
            avail_d[sel]        = sum_sat;
            rel_pos_d[sel]      = rel_pos_q[sel] + POS_BITS'(cmd_i.count);
            out_data_d.granted  = cmd_i.count;
            out_data_d.accepted = 1'b1;
          end
        end
        OP_INIT: begin
          avail_d[0]          = cmd_i.init_cap;
          avail_d[1]          = '0;
          rsv_pos_d[0]        = '0;
          rsv_pos_d[1]        = '0;
          rel_pos_d[0]        = '0;
          rel_pos_d[1]        = '0;
          out_data_d.granted  = cmd_i.init_cap;
          out_data_d.accepted = 1'b1;
        end
      endcase
    end
  end

  // slot state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q[0]   <= load_capacity(CAP_LOG2_RST, 6'(MAX_LOG2));
      avail_q[1]   <= '0;
      rsv_pos_q[0] <= '0;
      rsv_pos_q[1] <= '0;
      rel_pos_q[0] <= '0;
      rel_pos_q[1] <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      avail_q     <= avail_d;
      rsv_pos_q   <= rsv_pos_d;
      rel_pos_q   <= rel_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

`ifndef NO_ASSERTIONS
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.accepted |->
      out_data_o.granted == '0 && out_data_o.position == '0)
    else $error("refused word carries a grant or position");

  a_pos_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.position != '0 |-> out_data_o.accepted)
    else $error("position given on a refused word");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_o)
    else $error("popped command gave no result");
`endif

endmodule

// ===== sv/ring_slot_reserve_release.sv =====
// path: an accepted word has its result on out_data_o after passing through the command
// queue, then the output register, and is held back while out_ready_i is low
// throughput: one word per cycle while out_ready_i is high, set by the update of the side's counters
// the two-entry command queue and the output register let input and output stall apart
// reset: producer side holds 2^10 slots, consumer side none, all positions zero,
// capacity register 10, queue and output empty
module ring_slot_reserve_release import rsr_pkg::*; #(
  parameter int MAX_LOG2 = 16,
  parameter int POS_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rsr_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rsr_out_t         out_data_o
);

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  rsr_cmd_t cmd_in;
  rsr_cmd_t cmd_out;

  // accept and classify
  rsr_front #(
    .MAX_LOG2 (MAX_LOG2)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (cmd_in)
  );

  // command queue
  rsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (cmd_out)
  );

  // slot accounting and result register
  rsr_back #(
    .MAX_LOG2 (MAX_LOG2),
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
